// ===== hdl/ffra_pkg.sv =====
package ffra_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_EXTENTS      = 64;
  localparam int DEF_MAX_HELD_BLOCKS  = 64;
  localparam int DEF_HEADER_BYTES     = 16;
  localparam int DEF_MIN_BLOCK_BYTES  = 32;
  localparam int DEF_REGION_ADDR_BITS = 24;

  // Fixed field widths
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 25;
  localparam int ALIGN_W     = 4;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int PAD_W       = 15;
  localparam int LOW_W       = 16;
  localparam int MIN_ROUND   = 8;
  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_MEM    = 3'd2,
    ST_NULL      = 3'd3,
    ST_OUTSIDE   = 3'd4,
    ST_CORRUPT   = 3'd5,
    ST_UNAVAIL   = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE   = 1'b0,
    REG_REGION = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    EXT_NOP   = 3'd0,
    EXT_ROT   = 3'd1,
    EXT_SET   = 3'd2,
    EXT_DEL   = 3'd3,
    EXT_INS   = 3'd4,
    EXT_MERGE = 3'd5
  } ext_op_t;

  typedef enum logic [2:0] {
    HLD_NOP   = 3'd0,
    HLD_ROT   = 3'd1,
    HLD_CLR   = 3'd2,
    HLD_WRITE = 3'd3,
    HLD_REL   = 3'd4
  } held_op_t;

  typedef struct packed {
    ext_op_t op;
    logic    here;
    logic    after;
  } ext_ctl_t;

  typedef struct packed {
    held_op_t op;
    logic     here;
  } held_ctl_t;

endpackage

// ===== hdl/ffra_ext_cell.sv =====
module ffra_ext_cell #(
  parameter int START_W = 24,
  parameter int LEN_W   = 25
) (
  input  logic               clk,
  input  ffra_pkg::ext_ctl_t ctl,
  input  logic [START_W-1:0] set_start,
  input  logic [LEN_W-1:0]   set_len,
  input  logic [START_W-1:0] next_start,
  input  logic [LEN_W-1:0]   next_len,
  input  logic [START_W-1:0] prev_start,
  input  logic [LEN_W-1:0]   prev_len,
  output logic [START_W-1:0] start,
  output logic [LEN_W-1:0]   len
);
  import ffra_pkg::*;

  logic [START_W-1:0] start_r;
  logic [LEN_W-1:0]   len_r;

  always_ff @(posedge clk) begin
    case (ctl.op)
      EXT_ROT: begin
        start_r <= next_start;
        len_r   <= next_len;
      end
      EXT_SET: begin
        if (ctl.here) begin
          start_r <= set_start;
          len_r   <= set_len;
        end
      end
      EXT_DEL: begin
        if (ctl.here || ctl.after) begin
          start_r <= next_start;
          len_r   <= next_len;
        end
      end
      EXT_INS: begin
        if (ctl.here) begin
          start_r <= set_start;
          len_r   <= set_len;
        end else if (ctl.after) begin
          start_r <= prev_start;
          len_r   <= prev_len;
        end
      end
      EXT_MERGE: begin
        if (ctl.here) begin
          start_r <= set_start;
          len_r   <= set_len;
        end else if (ctl.after) begin
          start_r <= next_start;
          len_r   <= next_len;
        end
      end
      default: begin
      end
    endcase
  end

  assign start = start_r;
  assign len   = len_r;

endmodule

// ===== hdl/ffra_held_cell.sv =====
module ffra_held_cell #(
  parameter int START_W = 24,
  parameter int LEN_W   = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffra_pkg::held_ctl_t           ctl,
  input  logic [ffra_pkg::ADDR_W-1:0]   set_user,
  input  logic [START_W-1:0]            set_start,
  input  logic [LEN_W-1:0]              set_len,
  input  logic                          next_valid,
  input  logic [ffra_pkg::ADDR_W-1:0]   next_user,
  input  logic [START_W-1:0]            next_start,
  input  logic [LEN_W-1:0]              next_len,
  output logic                          valid,
  output logic [ffra_pkg::ADDR_W-1:0]   user,
  output logic [START_W-1:0]            start,
  output logic [LEN_W-1:0]              len
);
  import ffra_pkg::*;

  logic               valid_r;
  logic [ADDR_W-1:0]  user_r;
  logic [START_W-1:0] start_r;
  logic [LEN_W-1:0]   len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (ctl.op)
        HLD_ROT:   valid_r <= next_valid;
        HLD_CLR:   valid_r <= 1'b0;
        HLD_WRITE: if (ctl.here) valid_r <= 1'b1;
        HLD_REL:   if (ctl.here) valid_r <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      HLD_ROT: begin
        user_r  <= next_user;
        start_r <= next_start;
        len_r   <= next_len;
      end
      HLD_WRITE: begin
        if (ctl.here) begin
          user_r  <= set_user;
          start_r <= set_start;
          len_r   <= set_len;
        end
      end
      default: begin
      end
    endcase
  end

  assign valid = valid_r;
  assign user  = user_r;
  assign start = start_r;
  assign len   = len_r;

endmodule

// ===== hdl/first_fit_region_allocator_core.sv =====
// Channel | Dir | Transfer when           | Payload
// in_     | in  | in_valid & in_ready     | cmd, req_bytes, req_align_log2, free_addr
// out_    | out | out_valid & out_ready   | status, grant_addr, used_bytes, overhead_bytes
// cfg_    | in  | cfg_valid & cfg_ready   | cfg_index (0 base, 1 region size), cfg_data
//
// One request at a time. An allocate scans the extent ring and the held ring together in
// one pass; a free first scans the held ring for its block, then the extent ring. Each
// pass rotates its rings once through their head cells.
// Early rejects (zero size, null, uninitialised, outside region) go from the prepare step
// straight to the edit step; a free of an unknown address ends after the held-ring scan.
// Reset is synchronous, active low; it leaves the region uninitialised.
// A result waiting in the output register holds the block in its last step until taken.
module first_fit_region_allocator_core
  import ffra_pkg::*;
#(
  parameter int MAX_EXTENTS      = DEF_MAX_EXTENTS,
  parameter int MAX_HELD_BLOCKS  = DEF_MAX_HELD_BLOCKS,
  parameter int HEADER_BYTES     = DEF_HEADER_BYTES,
  parameter int MIN_BLOCK_BYTES  = DEF_MIN_BLOCK_BYTES,
  parameter int REGION_ADDR_BITS = DEF_REGION_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [SIZE_W-1:0]    in_req_bytes,
  input  logic [ALIGN_W-1:0]   in_req_align_log2,
  input  logic [ADDR_W-1:0]    in_free_addr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [ADDR_W-1:0]    out_grant_addr,
  output logic [SIZE_W-1:0]    out_used_bytes,
  output logic [SIZE_W-1:0]    out_overhead_bytes,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int AW    = REGION_ADDR_BITS;
  localparam int LW    = AW + 1;
  localparam int CW    = (LW > 27) ? LW : 27;
  localparam int EI    = $clog2(MAX_EXTENTS);
  localparam int CNTW  = $clog2(MAX_EXTENTS + 1);
  localparam int HI    = $clog2(MAX_HELD_BLOCKS);
  localparam int SD    = (MAX_EXTENTS > MAX_HELD_BLOCKS) ? MAX_EXTENTS : MAX_HELD_BLOCKS;
  localparam int STEPW = $clog2(SD + 4);
  localparam logic [STEPW-1:0] LAST_STEP  = STEPW'(SD + 2);
  localparam logic [STEPW-1:0] HLAST_STEP = STEPW'(MAX_HELD_BLOCKS - 1);
  localparam logic [STEPW-1:0] EXT_STEPS  = STEPW'(MAX_EXTENTS);
  localparam logic [STEPW-1:0] HLD_STEPS  = STEPW'(MAX_HELD_BLOCKS);
  localparam logic [CW-1:0]    MIN_C      = CW'(MIN_BLOCK_BYTES);
  localparam logic [CW-1:0]    HDR_C      = CW'(HEADER_BYTES);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_HSCAN = 6'b000100,
    S_XSCAN = 6'b001000,
    S_CALC  = 6'b010000,
    S_EDIT  = 6'b100000
  } state_t;

  state_t state_r;

  // Configuration and totals
  logic [ADDR_W-1:0] base_r;
  logic [LW-1:0]     live_r;
  logic              ready_r;
  logic [CNTW-1:0]   count_r;
  logic [SIZE_W-1:0] used_r;
  logic [SIZE_W-1:0] ovh_r;

  // Latched request
  logic              cmd_r;
  logic [SIZE_W-1:0] bytes_r;
  logic [ALIGN_W-1:0] alog_r;
  logic [ADDR_W-1:0] ptr_r;
  logic [CW-1:0]     need_r;
  logic [PAD_W-1:0]  mask_r;

  logic [STEPW-1:0]  step_r;

  // Fit pipeline
  logic              pa_v_r, pb_v_r;
  logic [EI-1:0]     pa_idx_r, pb_idx_r;
  logic [AW-1:0]     pa_start_r, pb_start_r;
  logic [LW-1:0]     pa_len_r, pb_len_r;
  logic [LOW_W-1:0]  pa_low_r;
  logic [PAD_W-1:0]  pb_pad_r;

  logic              found_r;
  logic [EI-1:0]     f_idx_r;
  logic [AW-1:0]     f_start_r;
  logic [LW-1:0]     f_len_r;
  logic [PAD_W-1:0]  f_pad_r;
  logic [CW-1:0]     f_take_r;

  logic              slot_found_r;
  logic [HI-1:0]     slot_r;

  // Free lookup and neighbor tracking
  logic              hfound_r;
  logic [HI-1:0]     hidx_r;
  logic [AW-1:0]     hstart_r;
  logic [LW-1:0]     hlen_r;
  logic              in_prefix_r;
  logic [CNTW-1:0]   pos_r;
  logic              prev_v_r, right_v_r;
  logic [AW-1:0]     prev_start_r, right_start_r;
  logic [LW-1:0]     prev_len_r, right_len_r;

  // Pending edit and result
  ext_op_t           ed_ext_op_r;
  logic [EI-1:0]     ed_p_r;
  logic [AW-1:0]     ed_start_r;
  logic [LW-1:0]     ed_len_r;
  logic              ed_inc_r, ed_dec_r;
  held_op_t          ed_held_op_r;
  logic [HI-1:0]     ed_slot_r;
  logic [ADDR_W-1:0] ed_user_r;
  logic [AW-1:0]     ed_hstart_r;
  logic [LW-1:0]     ed_hlen_r;
  status_t           res_status_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic [SIZE_W-1:0] res_used_r;
  logic [SIZE_W-1:0] res_ovh_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [SIZE_W-1:0]   out_used_r;
  logic [SIZE_W-1:0]   out_ovh_r;

  // Cell chains
  logic [AW-1:0]     ext_start [MAX_EXTENTS];
  logic [LW-1:0]     ext_len   [MAX_EXTENTS];
  ext_ctl_t          ext_ctl   [MAX_EXTENTS];
  logic              hld_valid [MAX_HELD_BLOCKS];
  logic [ADDR_W-1:0] hld_user  [MAX_HELD_BLOCKS];
  logic [AW-1:0]     hld_start [MAX_HELD_BLOCKS];
  logic [LW-1:0]     hld_len   [MAX_HELD_BLOCKS];
  held_ctl_t         hld_ctl   [MAX_HELD_BLOCKS];

  // Broadcast controls
  ext_op_t           ext_op;
  logic [EI-1:0]     ext_p;
  logic [AW-1:0]     ext_set_start;
  logic [LW-1:0]     ext_set_len;
  held_op_t          hld_op;
  logic [HI-1:0]     hld_p;

  logic in_fire, cfg_fire, edit_fire, cfg_region;
  logic ext_rot, hld_rot;

  logic [CW-1:0] cfg_size, cfg_limit, cfg_live;
  logic          cfg_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_region = cfg_fire && (cfg_index == REG_REGION);
  assign edit_fire = (state_r == S_EDIT) && (!out_valid_r || out_ready);

  // Clamp the region to the addressable span
  assign cfg_size  = CW'(cfg_data[SIZE_W-1:0]);
  assign cfg_limit = CW'(1) << AW;
  assign cfg_live  = (cfg_size > cfg_limit) ? cfg_limit : cfg_size;
  assign cfg_ok    = cfg_live >= CW'(2 * MIN_BLOCK_BYTES);

  assign ext_rot = (state_r == S_XSCAN) && (step_r < EXT_STEPS);
  assign hld_rot = ((state_r == S_HSCAN) || ((state_r == S_XSCAN) && !cmd_r)) &&
                   (step_r < HLD_STEPS);

  // Extent ring control: init has priority, then rotation, then the edit step
  always_comb begin
    ext_op        = EXT_NOP;
    ext_p         = '0;
    ext_set_start = ed_start_r;
    ext_set_len   = ed_len_r;
    if (cfg_region) begin
      ext_op        = EXT_SET;
      ext_set_start = '0;
      ext_set_len   = LW'(cfg_live);
    end else if (ext_rot) begin
      ext_op = EXT_ROT;
    end else if (edit_fire) begin
      ext_op = ed_ext_op_r;
      ext_p  = ed_p_r;
    end
  end

  always_comb begin
    hld_op = HLD_NOP;
    hld_p  = ed_slot_r;
    if (cfg_region) begin
      hld_op = HLD_CLR;
    end else if (hld_rot) begin
      hld_op = HLD_ROT;
    end else if (edit_fire) begin
      hld_op = ed_held_op_r;
    end
  end

  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_ext
    localparam int NX = (i + 1) % MAX_EXTENTS;
    localparam int PV = (i + MAX_EXTENTS - 1) % MAX_EXTENTS;
    assign ext_ctl[i].op    = ext_op;
    assign ext_ctl[i].here  = (ext_p == EI'(i));
    assign ext_ctl[i].after = (EI'(i) > ext_p);
    ffra_ext_cell #(.START_W(AW), .LEN_W(LW)) u_cell (
      .clk        (clk),
      .ctl        (ext_ctl[i]),
      .set_start  (ext_set_start),
      .set_len    (ext_set_len),
      .next_start (ext_start[NX]),
      .next_len   (ext_len[NX]),
      .prev_start (ext_start[PV]),
      .prev_len   (ext_len[PV]),
      .start      (ext_start[i]),
      .len        (ext_len[i])
    );
  end

  for (genvar i = 0; i < MAX_HELD_BLOCKS; i++) begin : g_hld
    localparam int NX = (i + 1) % MAX_HELD_BLOCKS;
    assign hld_ctl[i].op   = hld_op;
    assign hld_ctl[i].here = (hld_p == HI'(i));
    ffra_held_cell #(.START_W(AW), .LEN_W(LW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (hld_ctl[i]),
      .set_user   (ed_user_r),
      .set_start  (ed_hstart_r),
      .set_len    (ed_hlen_r),
      .next_valid (hld_valid[NX]),
      .next_user  (hld_user[NX]),
      .next_start (hld_start[NX]),
      .next_len   (hld_len[NX]),
      .valid      (hld_valid[i]),
      .user       (hld_user[i]),
      .start      (hld_start[i]),
      .len        (hld_len[i])
    );
  end

  // Request preparation: size rounding and early rejects
  logic [LOW_W-1:0]  align_w, round_w;
  logic [CW-1:0]     rmask_w, rounded_w, need0_w;
  logic [ADDR_W-1:0] off_w;
  logic              outside_w;

  assign align_w   = LOW_W'(1) << alog_r;
  assign round_w   = (align_w > LOW_W'(MIN_ROUND)) ? align_w : LOW_W'(MIN_ROUND);
  assign rmask_w   = CW'(round_w - LOW_W'(1));
  assign rounded_w = (CW'(bytes_r) + rmask_w) & ~rmask_w;
  assign need0_w   = rounded_w + HDR_C;
  assign off_w     = ptr_r - base_r;
  assign outside_w = ({1'b0, off_w} >= (ADDR_W + 1)'(live_r));

  // Head-cell views during a pass
  logic          ext_head_v;
  logic          lt_head;
  logic          hmatch;
  logic [CW-1:0] take_c;
  logic          fit_c;

  assign ext_head_v = (step_r < EXT_STEPS) && (32'(step_r) < 32'(count_r));
  assign lt_head    = ext_head_v && (ext_start[0] < hstart_r);
  assign hmatch     = (step_r < HLD_STEPS) && hld_valid[0] && (hld_user[0] == ptr_r);
  assign take_c     = need_r + CW'(pb_pad_r);
  assign fit_c      = pb_v_r && (CW'(pb_len_r) >= take_c);

  // Final arithmetic for the edit step
  logic [CW-1:0]     rem_w, take_fin_w;
  logic              split_w;
  logic [SIZE_W:0]   ovh_sum_w;
  logic [CW-1:0]     sum_left_w, sum_right_w;
  logic              left_w, right_w;

  assign rem_w       = CW'(f_len_r) - f_take_r;
  assign split_w     = rem_w >= MIN_C;
  assign take_fin_w  = split_w ? f_take_r : CW'(f_len_r);
  assign ovh_sum_w   = (SIZE_W + 1)'(ovh_r) + (SIZE_W + 1)'(HEADER_BYTES) +
                       (SIZE_W + 1)'(f_pad_r);
  assign sum_left_w  = CW'(prev_start_r) + CW'(prev_len_r);
  assign sum_right_w = CW'(hstart_r) + CW'(hlen_r);
  assign left_w      = prev_v_r && (sum_left_w == CW'(hstart_r));
  assign right_w     = right_v_r && (sum_right_w == CW'(right_start_r));

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      live_r      <= '0;
      ready_r     <= 1'b0;
      count_r     <= '0;
      used_r      <= '0;
      ovh_r       <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          REG_BASE: base_r <= cfg_data;
          REG_REGION: begin
            live_r  <= LW'(cfg_live);
            ready_r <= cfg_ok;
            count_r <= cfg_ok ? CNTW'(1) : '0;
            used_r  <= '0;
            ovh_r   <= '0;
          end
          default: begin
          end
        endcase
      end
      // Drop the result once taken, unless a new one replaces it
      if (out_valid_r && out_ready && !edit_fire) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_fire) state_r <= S_PREP;
        S_PREP: begin
          if (!cmd_r) begin
            state_r <= (bytes_r == '0 || !ready_r) ? S_EDIT : S_XSCAN;
          end else begin
            state_r <= (ptr_r == '0 || !ready_r || outside_w) ? S_EDIT : S_HSCAN;
          end
        end
        S_HSCAN: if (step_r == HLAST_STEP) state_r <= (hfound_r || hmatch) ? S_XSCAN : S_EDIT;
        S_XSCAN: if (step_r == LAST_STEP) state_r <= S_CALC;
        S_CALC:  state_r <= S_EDIT;
        S_EDIT: begin
          if (edit_fire) begin
            out_valid_r <= 1'b1;
            used_r      <= res_used_r;
            ovh_r       <= res_ovh_r;
            if (ed_inc_r) count_r <= count_r + CNTW'(1);
            if (ed_dec_r) count_r <= count_r - CNTW'(1);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_cmd;
      bytes_r <= in_req_bytes;
      alog_r  <= in_req_align_log2;
      ptr_r   <= in_free_addr;
    end

    // Fit pipeline: low address bits, then padding, then the fit test
    pa_v_r     <= (state_r == S_XSCAN) && !cmd_r && ext_head_v;
    pa_idx_r   <= step_r[EI-1:0];
    pa_start_r <= ext_start[0];
    pa_len_r   <= ext_len[0];
    pa_low_r   <= base_r[LOW_W-1:0] + LOW_W'(ext_start[0]) + LOW_W'(HEADER_BYTES);
    pb_v_r     <= pa_v_r;
    pb_idx_r   <= pa_idx_r;
    pb_start_r <= pa_start_r;
    pb_len_r   <= pa_len_r;
    pb_pad_r   <= PAD_W'(~pa_low_r + LOW_W'(1)) & mask_r;

    case (state_r)
      S_PREP: begin
        step_r       <= '0;
        need_r       <= (need0_w < MIN_C) ? MIN_C : need0_w;
        mask_r       <= PAD_W'(align_w - LOW_W'(1));
        found_r      <= 1'b0;
        slot_found_r <= 1'b0;
        hfound_r     <= 1'b0;
        in_prefix_r  <= 1'b1;
        pos_r        <= '0;
        prev_v_r     <= 1'b0;
        right_v_r    <= 1'b0;
        ed_ext_op_r  <= EXT_NOP;
        ed_held_op_r <= HLD_NOP;
        ed_inc_r     <= 1'b0;
        ed_dec_r     <= 1'b0;
        res_addr_r   <= '0;
        res_used_r   <= used_r;
        res_ovh_r    <= ovh_r;
        if (!cmd_r) begin
          res_status_r <= (bytes_r == '0) ? ST_ZERO_SIZE : ST_UNAVAIL;
        end else if (ptr_r == '0) begin
          res_status_r <= ST_NULL;
        end else if (!ready_r) begin
          res_status_r <= ST_UNAVAIL;
        end else begin
          res_status_r <= outside_w ? ST_OUTSIDE : ST_CORRUPT;
        end
      end
      S_HSCAN: begin
        step_r <= (step_r == HLAST_STEP) ? '0 : step_r + STEPW'(1);
        if (hmatch && !hfound_r) begin
          hfound_r <= 1'b1;
          hidx_r   <= step_r[HI-1:0];
          hstart_r <= hld_start[0];
          hlen_r   <= hld_len[0];
        end
      end
      S_XSCAN: begin
        step_r <= step_r + STEPW'(1);
        if (!cmd_r) begin
          if (fit_c && !found_r) begin
            found_r   <= 1'b1;
            f_idx_r   <= pb_idx_r;
            f_start_r <= pb_start_r;
            f_len_r   <= pb_len_r;
            f_pad_r   <= pb_pad_r;
            f_take_r  <= take_c;
          end
          if ((step_r < HLD_STEPS) && !hld_valid[0] && !slot_found_r) begin
            slot_found_r <= 1'b1;
            slot_r       <= step_r[HI-1:0];
          end
        end else if (in_prefix_r) begin
          // Advance past extents below the freed block; capture the first one above it
          if (lt_head) begin
            pos_r        <= pos_r + CNTW'(1);
            prev_v_r     <= 1'b1;
            prev_start_r <= ext_start[0];
            prev_len_r   <= ext_len[0];
          end else begin
            in_prefix_r   <= 1'b0;
            right_v_r     <= ext_head_v;
            right_start_r <= ext_start[0];
            right_len_r   <= ext_len[0];
          end
        end
      end
      S_CALC: begin
        if (!cmd_r) begin
          if (!slot_found_r) begin
            res_status_r <= ST_UNAVAIL;
          end else if (!found_r) begin
            res_status_r <= ST_NO_MEM;
          end else begin
            res_status_r <= ST_OK;
            ed_p_r       <= f_idx_r;
            if (split_w) begin
              ed_ext_op_r <= EXT_SET;
              ed_start_r  <= AW'(CW'(f_start_r) + f_take_r);
              ed_len_r    <= LW'(rem_w);
            end else begin
              ed_ext_op_r <= EXT_DEL;
              ed_dec_r    <= 1'b1;
            end
            res_addr_r   <= base_r + ADDR_W'(f_start_r) + ADDR_W'(HEADER_BYTES) +
                            ADDR_W'(f_pad_r);
            ed_user_r    <= base_r + ADDR_W'(f_start_r) + ADDR_W'(HEADER_BYTES) +
                            ADDR_W'(f_pad_r);
            ed_held_op_r <= HLD_WRITE;
            ed_slot_r    <= slot_r;
            ed_hstart_r  <= f_start_r;
            ed_hlen_r    <= LW'(take_fin_w);
            res_used_r   <= used_r + SIZE_W'(take_fin_w);
            res_ovh_r    <= (ovh_sum_w > (SIZE_W + 1)'(SIZE_MAX)) ? SIZE_MAX :
                            SIZE_W'(ovh_sum_w);
          end
        end else begin
          if (!left_w && !right_w && (32'(count_r) >= 32'(MAX_EXTENTS))) begin
            res_status_r <= ST_UNAVAIL;
          end else begin
            res_status_r <= ST_OK;
            ed_held_op_r <= HLD_REL;
            ed_slot_r    <= hidx_r;
            res_used_r   <= (CW'(used_r) >= CW'(hlen_r)) ?
                            SIZE_W'(CW'(used_r) - CW'(hlen_r)) : '0;
            if (left_w && right_w) begin
              ed_ext_op_r <= EXT_MERGE;
              ed_p_r      <= EI'(pos_r - CNTW'(1));
              ed_start_r  <= prev_start_r;
              ed_len_r    <= prev_len_r + hlen_r + right_len_r;
              ed_dec_r    <= 1'b1;
            end else if (left_w) begin
              ed_ext_op_r <= EXT_SET;
              ed_p_r      <= EI'(pos_r - CNTW'(1));
              ed_start_r  <= prev_start_r;
              ed_len_r    <= prev_len_r + hlen_r;
            end else if (right_w) begin
              ed_ext_op_r <= EXT_SET;
              ed_p_r      <= EI'(pos_r);
              ed_start_r  <= hstart_r;
              ed_len_r    <= hlen_r + right_len_r;
            end else begin
              ed_ext_op_r <= EXT_INS;
              ed_p_r      <= EI'(pos_r);
              ed_start_r  <= hstart_r;
              ed_len_r    <= hlen_r;
              ed_inc_r    <= 1'b1;
            end
          end
        end
      end
      S_EDIT: begin
        if (edit_fire) begin
          out_status_r <= res_status_r;
          out_addr_r   <= res_addr_r;
          out_used_r   <= res_used_r;
          out_ovh_r    <= res_ovh_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_grant_addr     = out_addr_r;
  assign out_used_bytes     = out_used_r;
  assign out_overhead_bytes = out_ovh_r;

endmodule

// ===== hdl/ffra_checker.sv =====
module ffra_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ffra_pkg::STATUS_W-1:0] out_status,
  input logic [ffra_pkg::ADDR_W-1:0]   out_grant_addr
);
  import ffra_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_grant_addr))
    else $error("stalled result changed");

  // A failed request never grants an address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_grant_addr == '0)
    else $error("address on failed request");

  // One request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted back to back");

  // No result emerges from reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_grant_addr (out_grant_addr)
);
